// ----- hdl/plist_pkg.sv -----
`timescale 1ns / 1ps

package plist_pkg;

    // fixed field widths on the request and result ports
    localparam int MODE_W = 2;
    localparam int POS_W  = 7;
    localparam int WORD_W = 32;
    localparam int LEN_W  = 7;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_APPEND = 2'd0;
    localparam mode_t MODE_INSERT = 2'd1;
    localparam mode_t MODE_REMOVE = 2'd2;
    localparam mode_t MODE_READ   = 2'd3;

endpackage

// ----- hdl/positional_list_engine.sv -----
`timescale 1ns / 1ps
// a request is taken when start is high and busy is low; busy then stays high until the shift ends
// k is the number of store reads: 1 for read, length-position for insert and remove, 0 for append
// when k is zero (append, or insert at the length) busy is high for one cycle only
// done rises as busy falls; a head remove of a full list reads every word and takes longest
// the store shift, one read and one write per cycle, sets how long a request takes
// a refused request gives done on the next cycle and leaves busy low; results cannot be stalled
// rst_n clears the length and the sequencer at once; store contents are undefined until written

module positional_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  plist_pkg::mode_t             mode,
    input  logic [plist_pkg::POS_W-1:0]  position,
    input  logic [plist_pkg::WORD_W-1:0] data_in,
    output logic                         busy,
    output logic                         done,
    output logic [plist_pkg::WORD_W-1:0] data_out,
    output logic                         ok,
    output logic [plist_pkg::LEN_W-1:0]  length
);

    import plist_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SHIFT = 1'b1;

    logic                  state_reg, state_next;
    mode_t                 op_reg, op_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         left_reg, left_next;
    logic                  pend_reg, pend_next;
    logic                  skip_reg, skip_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  done_reg, done_next;
    logic                  ok_reg, ok_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic [DATA_WIDTH-1:0] result_reg, result_next;

    logic [DATA_WIDTH-1:0] word_in;
    logic [CMP_W-1:0]      count_ext;
    logic [CMP_W-1:0]      eff_pos;
    logic [CMP_W-1:0]      span;
    logic                  is_ins;
    logic                  req_valid;

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_rd_data;

    generate
        if (DATA_WIDTH <= WORD_W)
        begin : g_narrow
            assign word_in  = data_in[DATA_WIDTH-1:0];
            assign data_out = WORD_W'(result_reg);
        end
        else
        begin : g_wide
            assign word_in  = {{(DATA_WIDTH - WORD_W){1'b0}}, data_in};
            assign data_out = result_reg[WORD_W-1:0];
        end

        if (CW >= LEN_W)
        begin : g_len_cut
            assign length = count_reg[LEN_W-1:0];
        end
        else
        begin : g_len_ext
            assign length = {{(LEN_W - CW){1'b0}}, count_reg};
        end
    endgenerate

    assign busy = (state_reg == ST_SHIFT);
    assign done = done_reg;
    assign ok   = ok_reg;

    // append is an insert at the current length
    assign count_ext = CMP_W'(count_reg);
    assign is_ins    = (mode == MODE_APPEND) || (mode == MODE_INSERT);
    assign eff_pos   = (mode == MODE_APPEND) ? count_ext : CMP_W'(position);
    assign span      = count_ext - eff_pos;
    assign req_valid = is_ins ? ((eff_pos <= count_ext) && (count_ext < CMP_W'(CAPACITY)))
                              : (eff_pos < count_ext);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        pos_next    = pos_reg;
        left_next   = left_reg;
        pend_next   = 1'b0;
        skip_next   = skip_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        ok_next     = ok_reg;
        word_next   = word_reg;
        result_next = result_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = wr_ptr_reg;
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = rd_ptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    result_next = '0;
                    if (!req_valid)
                    begin
                        done_next = 1'b1;
                        ok_next   = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                        pos_next   = eff_pos[AW-1:0];
                        word_next  = word_in;
                        left_next  = span[CW-1:0];
                        if (is_ins)
                        begin
                            // walk from the tail down, each word moves up one
                            op_next     = MODE_INSERT;
                            rd_ptr_next = count_reg[AW-1:0] - AW'(1);
                            wr_ptr_next = count_reg[AW-1:0];
                            skip_next   = 1'b0;
                        end
                        else
                        begin
                            // first word read is the result, later ones move down one
                            op_next     = mode;
                            rd_ptr_next = eff_pos[AW-1:0];
                            wr_ptr_next = eff_pos[AW-1:0];
                            skip_next   = 1'b1;
                            if (mode == MODE_READ)
                            begin
                                left_next = CW'(1);
                            end
                        end
                    end
                end
            end

            ST_SHIFT:
            begin
                if (left_reg != '0)
                begin
                    mem_rd_en = 1'b1;
                    pend_next = 1'b1;
                    left_next = left_reg - CW'(1);
                    if (op_reg == MODE_INSERT)
                    begin
                        rd_ptr_next = rd_ptr_reg - AW'(1);
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                    end
                end

                if (pend_reg)
                begin
                    if (skip_reg)
                    begin
                        result_next = mem_rd_data;
                        skip_next   = 1'b0;
                    end
                    else
                    begin
                        mem_wr_en = 1'b1;
                        if (op_reg == MODE_INSERT)
                        begin
                            wr_ptr_next = wr_ptr_reg - AW'(1);
                        end
                        else
                        begin
                            wr_ptr_next = wr_ptr_reg + AW'(1);
                        end
                    end
                end
                else if (left_reg == '0)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    case (op_reg)
                        MODE_INSERT:
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = pos_reg;
                            mem_wr_data = word_reg;
                            count_next  = count_reg + CW'(1);
                        end
                        MODE_REMOVE:
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= MODE_READ;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
            skip_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
            skip_reg  <= skip_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        pos_reg    <= pos_next;
        word_reg   <= word_next;
        result_reg <= result_next;
    end

    plist_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ----- hdl/plist_ram.sv -----
`timescale 1ns / 1ps

module plist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/plist_checker.sv -----
`timescale 1ns / 1ps

module plist_checker #(
    parameter int CAPACITY = 64
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [plist_pkg::WORD_W-1:0] data_out,
    input logic                         ok,
    input logic [plist_pkg::LEN_W-1:0]  length
);

    import plist_pkg::*;

    // a refused request never returns data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ok |-> data_out == '0)
        else $error("refused request returned nonzero data");

    // the length moves only together with a result
    a_len_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(length) |-> done)
        else $error("length changed without a result");

    // the sequencer starts only on a request
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // a result always leaves the block free for the next request
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (CAPACITY > 127) || (length <= LEN_W'(CAPACITY)))
        else $error("length above capacity");

endmodule

bind positional_list_engine plist_checker #(
    .CAPACITY (CAPACITY)
) u_plist_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .data_out (data_out),
    .ok       (ok),
    .length   (length)
);
